/* design/omni_wheel_mix_saturate_defines.svh */
// Assertion macros for the checker file of the wheel mixer.
`ifndef OMNI_WHEEL_MIX_SATURATE_DEFINES_SVH
`define OMNI_WHEEL_MIX_SATURATE_DEFINES_SVH

// Concurrent assertion that is switched off while reset is high.
`define OWM_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("omni wheel mixer assertion failed");

// Concurrent assertion that is also checked during reset.
`define OWM_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("omni wheel mixer reset assertion failed");

`endif

/* design/owm_pkg.sv */
`default_nettype none
package owm_pkg;

  localparam int FRAC_BITS = 14;
  localparam logic signed [15:0] ONE_Q = 16'sd16384;

  localparam int EPS_W = 10;
  localparam logic [EPS_W-1:0] EPS_RESET = 10'd1;

  localparam int ADDR_W = 3;
  localparam logic REG_EPSILON = 1'b0;

  localparam int SQRT_STAGES = 16;

  typedef struct packed {
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] spin;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] wheel_a;
    logic signed [15:0] wheel_b;
    logic signed [15:0] wheel_c;
    logic signed [15:0] wheel_d;
  } wheel_t;

  // Values that ride alongside the square root pipeline.
  typedef struct packed {
    logic signed [15:0] w;
    logic signed [16:0] p0;
    logic signed [16:0] p1;
    logic               tiny;
  } side_t;

  function automatic logic signed [15:0] clamp_q(input logic signed [34:0] v);
    logic signed [34:0] c;
    begin
      c = v;
      if (v > 35'sd16384) c = 35'sd16384;
      if (v < -35'sd16384) c = -35'sd16384;
      return c[15:0];
    end
  endfunction

endpackage
`default_nettype wire

/* design/omni_wheel_mix_saturate.sv */
// Four-wheel omni base mixer with box saturation.
// A body command (vel_x, vel_y, spin, signed Q2.14) enters on the cmd channel
// and four wheel drives, each clamped to [-1, 1], leave on the wheel channel.
// A transaction completes on a rising edge where valid is high and stall low.
// The single register, epsilon, sits at byte address 0 of the APB port; the user
// must write it only while the block holds no work, which the block does not enforce.
// An accepted command passes through two input stages, 16 square root stages,
// 16 direction divide stages, one select stage, 29 distance divide stages and
// three multiply and output stages on its way to the wheel transaction.
// Throughput is one transaction per cycle while the receiver does not stall;
// each root or divide stage is one bit step, and all stages advance together.
// When the receiver stalls while a result is waiting, the whole pipeline
// holds and cmd_stall rises; nothing is dropped or repeated.
// Synchronous reset empties the pipeline and sets epsilon to 1.
`default_nettype none
module omni_wheel_mix_saturate import owm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  cmd_t              cmd,
  output logic              wheel_valid,
  input  logic              wheel_stall,
  output wheel_t            wheel
);

  localparam int EDIV_STAGES = 16;
  localparam int TDIV_STAGES = 29;

  // Direction divide: |p| * 2^F / (2 * norm), one quotient bit per stage.
  typedef struct packed {
    logic signed [15:0] w;
    logic               s0;
    logic               s1;
    logic               tiny;
    logic [15:0]        norm;
    logic [30:0]        rem0;
    logic [30:0]        rem1;
    logic [15:0]        q0;
    logic [15:0]        q1;
  } ed_t;

  // Distance divide: m * 2^F / emax, one quotient bit per stage.
  typedef struct packed {
    logic signed [15:0] w;
    logic               s0;
    logic               s1;
    logic               tiny;
    logic               zero_t;
    logic [15:0]        norm;
    logic [15:0]        e0m;
    logic [15:0]        e1m;
    logic [15:0]        dv;
    logic [28:0]        rem;
    logic [28:0]        q;
  } td_t;

  // Configuration register. Writes are decoded on the word address bit.
  logic [EPS_W-1:0] epsilon;

  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1] == REG_EPSILON) ? {{(32-EPS_W){1'b0}}, epsilon} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= EPS_RESET;
    end else if (psel && penable && pwrite && pready && paddr[ADDR_W-1] == REG_EPSILON) begin
      epsilon <= pwdata[EPS_W-1:0];
    end
  end

  // The pipeline moves as a unit unless a finished result is being held back.
  logic adv;
  assign adv       = !(wheel_valid && wheel_stall);
  assign cmd_stall = !adv;

  // Stage A: command register.
  logic a_valid;
  cmd_t a_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) a_cmd <= cmd;
  end

  // Stage B: squared norm and the difference and sum translation terms.
  logic               b_valid;
  logic [31:0]        b_nsq;
  logic signed [15:0] b_w;
  logic signed [16:0] b_p0;
  logic signed [16:0] b_p1;
  logic signed [31:0] sq_x;
  logic signed [31:0] sq_y;
  logic signed [16:0] vx_ext;
  logic signed [16:0] vy_ext;

  assign sq_x   = a_cmd.vel_x * a_cmd.vel_x;
  assign sq_y   = a_cmd.vel_y * a_cmd.vel_y;
  assign vx_ext = {a_cmd.vel_x[15], a_cmd.vel_x};
  assign vy_ext = {a_cmd.vel_y[15], a_cmd.vel_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_nsq <= $unsigned(sq_x) + $unsigned(sq_y);
      b_w   <= a_cmd.spin;
      b_p0  <= vx_ext - vy_ext;
      b_p1  <= vx_ext + vy_ext;
    end
  end

  // A translation below the threshold leaves only the clamped rotation.
  side_t b_side;
  assign b_side.w    = b_w;
  assign b_side.p0   = b_p0;
  assign b_side.p1   = b_p1;
  assign b_side.tiny = (b_nsq == '0) ||
                       (b_nsq < {{(32-EPS_W-FRAC_BITS){1'b0}}, epsilon, {FRAC_BITS{1'b0}}});

  logic        r_valid;
  logic [15:0] r_root;
  side_t       r_side;

  owm_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (b_valid),
    .radicand  (b_nsq),
    .in_side   (b_side),
    .out_valid (r_valid),
    .root      (r_root),
    .out_side  (r_side)
  );

  // Magnitudes of the translation terms; p1 can reach -65536, hence 17 bits.
  logic [16:0] p0_mag;
  logic [16:0] p1_mag;
  ed_t         ed_head;

  assign p0_mag = r_side.p0[16] ? 17'(-r_side.p0) : 17'(r_side.p0);
  assign p1_mag = r_side.p1[16] ? 17'(-r_side.p1) : 17'(r_side.p1);

  assign ed_head.w    = r_side.w;
  assign ed_head.s0   = r_side.p0[16];
  assign ed_head.s1   = r_side.p1[16];
  assign ed_head.tiny = r_side.tiny;
  assign ed_head.norm = r_root;
  assign ed_head.rem0 = {p0_mag, {FRAC_BITS{1'b0}}};
  assign ed_head.rem1 = {p1_mag, {FRAC_BITS{1'b0}}};
  assign ed_head.q0   = '0;
  assign ed_head.q1   = '0;

  logic ed_vld [0:EDIV_STAGES-1];
  ed_t  ed     [0:EDIV_STAGES-1];

  genvar j;
  for (j = 0; j < EDIV_STAGES; j++) begin : g_ediv
    localparam int B = EDIV_STAGES - 1 - j;
    logic        vld_in;
    ed_t         cur;
    ed_t         nxt;
    logic [31:0] dsh;

    if (j == 0) begin : g_head
      assign vld_in = r_valid;
      assign cur    = ed_head;
    end else begin : g_link
      assign vld_in = ed_vld[j-1];
      assign cur    = ed[j-1];
    end

    assign dsh = {15'b0, cur.norm, 1'b0} << B;

    always_comb begin
      nxt = cur;
      if ({1'b0, cur.rem0} >= dsh) begin
        nxt.rem0  = 31'({1'b0, cur.rem0} - dsh);
        nxt.q0[B] = 1'b1;
      end
      if ({1'b0, cur.rem1} >= dsh) begin
        nxt.rem1  = 31'({1'b0, cur.rem1} - dsh);
        nxt.q1[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ed_vld[j] <= 1'b0;
      end else if (adv) begin
        ed_vld[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) ed[j] <= nxt;
    end
  end

  // Select stage. The opposite wheels carry the negated direction, so only
  // two axes need testing, and the nearest face is reached along the axis
  // with the largest usable direction magnitude.
  ed_t                e_out;
  logic               ax0_ok;
  logic               ax1_ok;
  logic               spin_out;
  logic signed [17:0] gap_lo;
  logic signed [17:0] gap_hi;
  logic [16:0]        gap_lo_mag;
  logic [16:0]        gap_hi_mag;
  logic [16:0]        gap_min;
  td_t                td_head;

  assign e_out      = ed[EDIV_STAGES-1];
  assign ax0_ok     = (e_out.q0 != '0) && (e_out.q0 >= {{(16-EPS_W){1'b0}}, epsilon});
  assign ax1_ok     = (e_out.q1 != '0) && (e_out.q1 >= {{(16-EPS_W){1'b0}}, epsilon});
  assign spin_out   = (e_out.w > ONE_Q) || (e_out.w < -ONE_Q);
  assign gap_lo     = 18'(e_out.w) + 18'(ONE_Q);
  assign gap_hi     = 18'(ONE_Q) - 18'(e_out.w);
  assign gap_lo_mag = gap_lo[17] ? 17'(-gap_lo) : 17'(gap_lo);
  assign gap_hi_mag = gap_hi[17] ? 17'(-gap_hi) : 17'(gap_hi);
  assign gap_min    = (gap_lo_mag < gap_hi_mag) ? gap_lo_mag : gap_hi_mag;

  always_comb begin
    td_head.w    = e_out.w;
    td_head.s0   = e_out.s0;
    td_head.s1   = e_out.s1;
    td_head.tiny = e_out.tiny;
    td_head.norm = e_out.norm;
    td_head.e0m  = e_out.q0;
    td_head.e1m  = e_out.q1;
    // A spin beyond the box with any axis parallel to the motion stops the
    // translation, as does having no usable axis at all.
    td_head.zero_t = !(ax0_ok || ax1_ok) || ((!ax0_ok || !ax1_ok) && spin_out);
    priority if (ax0_ok && ax1_ok) begin
      td_head.dv = (e_out.q0 > e_out.q1) ? e_out.q0 : e_out.q1;
    end else if (ax0_ok) begin
      td_head.dv = e_out.q0;
    end else if (ax1_ok) begin
      td_head.dv = e_out.q1;
    end else begin
      td_head.dv = 16'd1;
    end
    td_head.rem = {gap_min[14:0], {FRAC_BITS{1'b0}}};
    td_head.q   = '0;
  end

  logic c_valid;
  td_t  c_td;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= ed_vld[EDIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) c_td <= td_head;
  end

  // Distance divide. The quotient is at most 2^28, under the
  // saturation limit of the distance.
  logic td_vld [0:TDIV_STAGES-1];
  td_t  td     [0:TDIV_STAGES-1];

  for (j = 0; j < TDIV_STAGES; j++) begin : g_tdiv
    localparam int B = TDIV_STAGES - 1 - j;
    logic        vld_in;
    td_t         cur;
    td_t         nxt;
    logic [44:0] dsh;

    if (j == 0) begin : g_head
      assign vld_in = c_valid;
      assign cur    = c_td;
    end else begin : g_link
      assign vld_in = td_vld[j-1];
      assign cur    = td[j-1];
    end

    assign dsh = {29'b0, cur.dv} << B;

    always_comb begin
      nxt = cur;
      if ({16'b0, cur.rem} >= dsh) begin
        nxt.rem  = 29'({16'b0, cur.rem} - dsh);
        nxt.q[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        td_vld[j] <= 1'b0;
      end else if (adv) begin
        td_vld[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) td[j] <= nxt;
    end
  end

  // Stage D: distance times norm.
  td_t                t_out;
  logic               d_valid;
  logic [44:0]        d_prod;
  logic signed [15:0] d_w;
  logic               d_s0;
  logic               d_s1;
  logic               d_tiny;
  logic [15:0]        d_e0m;
  logic [15:0]        d_e1m;

  assign t_out = td[TDIV_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (adv) begin
      d_valid <= td_vld[TDIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_prod <= t_out.zero_t ? '0 : 45'(t_out.q) * 45'(t_out.norm);
      d_w    <= t_out.w;
      d_s0   <= t_out.s0;
      d_s1   <= t_out.s1;
      d_tiny <= t_out.tiny;
      d_e0m  <= t_out.e0m;
      d_e1m  <= t_out.e1m;
    end
  end

  // Stage E: direction magnitude times scale.
  logic [30:0]        scale;
  logic               e_valid;
  logic [46:0]        e_prod0;
  logic [46:0]        e_prod1;
  logic signed [15:0] e_w;
  logic               e_s0;
  logic               e_s1;
  logic               e_tiny;

  assign scale = d_prod[FRAC_BITS +: 31];

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (adv) begin
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_prod0 <= 47'(d_e0m) * 47'(scale);
      e_prod1 <= 47'(d_e1m) * 47'(scale);
      e_w     <= d_w;
      e_s0    <= d_s0;
      e_s1    <= d_s1;
      e_tiny  <= d_tiny;
    end
  end

  // Output stage: signed offsets around the spin, or the spin alone for a tiny translation, then the box clamp.
  logic signed [34:0] step0;
  logic signed [34:0] step1;
  logic signed [34:0] w_ext;

  assign step0 = e_s0 ? -$signed({2'b0, e_prod0[FRAC_BITS +: 33]})
                      :  $signed({2'b0, e_prod0[FRAC_BITS +: 33]});
  assign step1 = e_s1 ? -$signed({2'b0, e_prod1[FRAC_BITS +: 33]})
                      :  $signed({2'b0, e_prod1[FRAC_BITS +: 33]});
  assign w_ext = 35'(e_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_valid <= 1'b0;
    end else if (adv) begin
      wheel_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (e_tiny) begin
        wheel.wheel_a <= clamp_q(w_ext);
        wheel.wheel_b <= clamp_q(w_ext);
        wheel.wheel_c <= clamp_q(w_ext);
        wheel.wheel_d <= clamp_q(w_ext);
      end else begin
        wheel.wheel_a <= clamp_q(w_ext + step0);
        wheel.wheel_b <= clamp_q(w_ext + step1);
        wheel.wheel_c <= clamp_q(w_ext - step0);
        wheel.wheel_d <= clamp_q(w_ext - step1);
      end
    end
  end

endmodule
`default_nettype wire

/* design/owm_isqrt.sv */
`default_nettype none
module owm_isqrt import owm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_valid,
  input  logic [31:0] radicand,
  input  side_t       in_side,
  output logic        out_valid,
  output logic [15:0] root,
  output side_t       out_side
);

  logic        vld  [0:SQRT_STAGES-1];
  side_t       side [0:SQRT_STAGES-1];
  logic [31:0] rem  [0:SQRT_STAGES-1];
  logic [31:0] res  [0:SQRT_STAGES-1];

  // One result bit per stage, digit-by-digit from the top bit pair down.
  genvar j;
  for (j = 0; j < SQRT_STAGES; j++) begin : g_stage
    localparam logic [31:0] BIT = 32'd1 << (30 - 2 * j);
    logic        vld_in;
    side_t       side_in;
    logic [31:0] rem_in;
    logic [31:0] res_in;
    logic [31:0] trial;

    if (j == 0) begin : g_head
      assign vld_in  = in_valid;
      assign side_in = in_side;
      assign rem_in  = radicand;
      assign res_in  = '0;
    end else begin : g_link
      assign vld_in  = vld[j-1];
      assign side_in = side[j-1];
      assign rem_in  = rem[j-1];
      assign res_in  = res[j-1];
    end

    assign trial = res_in + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (adv) begin
        vld[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        side[j] <= side_in;
        if (rem_in >= trial) begin
          rem[j] <= rem_in - trial;
          res[j] <= (res_in >> 1) + BIT;
        end else begin
          rem[j] <= rem_in;
          res[j] <= res_in >> 1;
        end
      end
    end
  end

  assign out_valid = vld[SQRT_STAGES-1];
  assign root      = res[SQRT_STAGES-1][15:0];
  assign out_side  = side[SQRT_STAGES-1];

endmodule
`default_nettype wire

/* design/owm_checker.sv */
`default_nettype none
`include "omni_wheel_mix_saturate_defines.svh"
module owm_checker import owm_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   cmd_valid,
  input logic   cmd_stall,
  input logic   wheel_valid,
  input logic   wheel_stall,
  input wheel_t wheel
);

  // The output channel is empty in the cycle after reset.
  `OWM_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !wheel_valid)

  // The command side only stalls because a result is being held back.
  `OWM_ASSERT(a_stall_cause, clk, rst, cmd_stall |-> (wheel_valid && wheel_stall))

  // A held-back result stays offered.
  `OWM_ASSERT(a_hold, clk, rst, (wheel_valid && wheel_stall) |=> wheel_valid)

  // A stalled command stays offered until it is taken.
  `OWM_ASSERT(a_cmd_hold, clk, rst, (cmd_valid && cmd_stall) |=> cmd_valid)

  // Every wheel drive lies inside the box.
  `OWM_ASSERT(a_box, clk, rst, wheel_valid |->
    (wheel.wheel_a <= ONE_Q && wheel.wheel_a >= -ONE_Q &&
     wheel.wheel_b <= ONE_Q && wheel.wheel_b >= -ONE_Q &&
     wheel.wheel_c <= ONE_Q && wheel.wheel_c >= -ONE_Q &&
     wheel.wheel_d <= ONE_Q && wheel.wheel_d >= -ONE_Q))

endmodule

bind omni_wheel_mix_saturate owm_checker u_owm_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd_valid),
  .cmd_stall   (cmd_stall),
  .wheel_valid (wheel_valid),
  .wheel_stall (wheel_stall),
  .wheel       (wheel)
);
`default_nettype wire
